/* sv/ipc_pkg.sv */
// Shared constants, codes and helper functions for the IR photometric pixel corrector.
// Used by ipc_offset_map and ir_photometric_pixel_correct; depends on nothing else.
`timescale 1ns / 1ps

package ipc_pkg;

    // Default frame and tile geometry.
    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 512;
    localparam int CELL_SIZE_DEF    = 16;

    // Fixed field widths of the stream and register interface.
    localparam int X_W      = 10;
    localparam int Y_W      = 9;
    localparam int PIX_W    = 8;
    localparam int OFFS_W   = 16;
    localparam int SLOPE_W  = 18;
    localparam int BIAS_W   = 20;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Bit positions of the slave-side tdata fields.
    localparam int X_LSB    = 0;
    localparam int Y_LSB    = X_LSB + X_W;
    localparam int PIX_LSB  = Y_LSB + Y_W;
    localparam int OFFS_LSB = PIX_LSB + PIX_W;

    // Fixed-point arithmetic: the sum carries 14 fraction bits.
    localparam int FRAC_BITS  = 14;
    localparam int LEVEL_SHL  = 6;
    localparam int PROD_W     = PIX_W + 1 + SLOPE_W;
    localparam int SUM_W      = 28;

    // Reciprocal multiply for the tile division, exact for 10-bit coordinates
    // and tile sizes up to 64.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int CPROD_W     = X_W + RECIP_W;

    // Register reset values.
    localparam logic [SLOPE_W-1:0] SLOPE_RESET = 18'd16384;
    localparam logic [BIAS_W-1:0]  BIAS_RESET  = 20'd0;

    // Register index decode (byte address bit 2).
    localparam logic REG_SLOPE = 1'b0;
    localparam logic REG_BIAS  = 1'b1;

    // Item modes carried on tuser.
    localparam logic MODE_CORRECT = 1'b0;
    localparam logic MODE_WRITE   = 1'b1;

    // Control group from the pipeline to the offset map.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } map_ctrl_t;

    // Triangle fold: 2v below 128, 255 at 128, 512 - 2v above.
    function automatic logic [PIX_W-1:0] fold_level(input logic [PIX_W-1:0] v);
        logic [PIX_W-1:0] neg;
        logic [PIX_W-1:0] res;
        neg = 8'd0 - v;
        if (!v[7])
        begin
            res = {v[6:0], 1'b0};
        end
        else if (v == 8'd128)
        begin
            res = 8'hFF;
        end
        else
        begin
            res = {neg[6:0], 1'b0};
        end
        return res;
    endfunction

endpackage

/* sv/ipc_offset_map.sv */
// Coarse spatial offset map: one 16-bit entry per tile, with a clearing pass after reset.
// Depends on ipc_pkg for the control struct and field widths.
`timescale 1ns / 1ps

module ipc_offset_map #(
    parameter int DEPTH = 1280,
    parameter int AW    = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ipc_pkg::map_ctrl_t           ctrl,
    input  logic [AW-1:0]                addr,
    input  logic [ipc_pkg::OFFS_W-1:0]   wdata,
    output logic [ipc_pkg::OFFS_W-1:0]   rdata,
    output logic                         clear_done
);

    logic [ipc_pkg::OFFS_W-1:0] mem [DEPTH];
    logic [AW:0]                clr_cnt_reg;
    logic [AW:0]                clr_cnt_next;
    logic [ipc_pkg::OFFS_W-1:0] rdata_reg;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [ipc_pkg::OFFS_W-1:0] wr_data;

    assign clear_done = (clr_cnt_reg == (AW+1)'(DEPTH));

    // Clearing pass counter: one entry per cycle after reset.
    assign clr_cnt_next = clear_done ? clr_cnt_reg : clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // The clearing pass owns the write port until it has finished.
    assign wr_en   = !clear_done || ctrl.wr_en;
    assign wr_addr = clear_done ? addr : clr_cnt_reg[AW-1:0];
    assign wr_data = clear_done ? wdata : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ir_photometric_pixel_correct.sv */
// Throughput: one item per cycle; each stage advances when the stage after it is free.
// Mode 1 items update the offset map if inside it and leave the pipeline without a result.
// Reset: registers return to slope 1.0 and bias 0, then a clearing pass zeroes the offset
// map, one entry per cycle over its FRAME_WIDTH/CELL_SIZE * FRAME_HEIGHT/CELL_SIZE entries
// (1280 by default), with s_tready low; configuration writes are taken throughout.
`timescale 1ns / 1ps

module ir_photometric_pixel_correct #(
    parameter int FRAME_WIDTH  = ipc_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = ipc_pkg::FRAME_HEIGHT_DEF,
    parameter int CELL_SIZE    = ipc_pkg::CELL_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: pixel_x[9:0], pixel_y[18:10], pixel_value[26:19], offset_value[42:27], zeros
    input  logic [ipc_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: mode[0]
    input  logic                          s_tuser,
    // Master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: corrected_pixel[7:0]
    output logic [ipc_pkg::M_DATA_W-1:0]  m_tdata,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipc_pkg::APB_AW-1:0]    paddr,
    input  logic [ipc_pkg::APB_DW-1:0]    pwdata,
    output logic [ipc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int MAP_COLS  = FRAME_WIDTH / CELL_SIZE;
    localparam int MAP_ROWS  = FRAME_HEIGHT / CELL_SIZE;
    localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
    localparam int MAP_SLOTS = (MAP_DEPTH < 2) ? 2 : MAP_DEPTH;
    localparam int AW        = $clog2(MAP_SLOTS);
    localparam int RECIP     = (2**ipc_pkg::RECIP_SHIFT + CELL_SIZE - 1) / CELL_SIZE;

    // Configuration registers.
    logic [ipc_pkg::SLOPE_W-1:0] slope_gain_reg;
    logic [ipc_pkg::BIAS_W-1:0]  bias_level_reg;
    logic                        cfg_wr;

    // Stage 1: tile coordinate products.
    logic                          v1_reg;
    logic                          mode1_reg;
    logic [ipc_pkg::CPROD_W-1:0]   xprod1_reg;
    logic [ipc_pkg::CPROD_W-1:0]   yprod1_reg;
    logic [ipc_pkg::PIX_W-1:0]     pix1_reg;
    logic [ipc_pkg::OFFS_W-1:0]    offs1_reg;

    // Stage 2: map index and gain product.
    logic                          v2_reg;
    logic                          mode2_reg;
    logic                          inside2_reg;
    logic [AW-1:0]                 idx2_reg;
    logic signed [ipc_pkg::PROD_W-1:0] prod2_reg;
    logic [ipc_pkg::OFFS_W-1:0]    offs2_reg;

    // Stage 3: partial sum, map read data held in the map.
    logic                          v3_reg;
    logic                          inside3_reg;
    logic signed [ipc_pkg::SUM_W-1:0] sum3_reg;

    // Stage 4: output register.
    logic                          v4_reg;
    logic [ipc_pkg::M_DATA_W-1:0]  pix4_reg;

    logic rdy1, rdy2, rdy3, rdy4;
    logic adv1, adv2, adv3, adv4;
    logic clear_done;

    logic [ipc_pkg::X_W-1:0]       cx1;
    logic [ipc_pkg::Y_W-1:0]       cy1;
    logic                          inside1;
    logic [AW-1:0]                 idx1;
    logic signed [ipc_pkg::PROD_W-1:0] prod1;
    logic signed [ipc_pkg::SUM_W-1:0]  sum2;
    logic signed [ipc_pkg::SUM_W-1:0]  sum3;
    logic signed [ipc_pkg::OFFS_W-1:0] map_rdata;
    logic signed [ipc_pkg::OFFS_W-1:0] offs3;
    ipc_pkg::map_ctrl_t            map_ctrl;

    // Configuration writes and reads.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_gain_reg <= ipc_pkg::SLOPE_RESET;
            bias_level_reg <= ipc_pkg::BIAS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ipc_pkg::REG_SLOPE: slope_gain_reg <= pwdata[ipc_pkg::SLOPE_W-1:0];
                ipc_pkg::REG_BIAS:  bias_level_reg <= pwdata[ipc_pkg::BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ipc_pkg::REG_SLOPE: prdata = ipc_pkg::APB_DW'(slope_gain_reg);
            ipc_pkg::REG_BIAS:  prdata = ipc_pkg::APB_DW'(bias_level_reg);
            default:            prdata = '0;
        endcase
    end

    // Per-stage flow control: a stage moves on when the next one is empty or moving.
    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1 && clear_done;

    assign adv1 = s_tvalid && s_tready;
    assign adv2 = v1_reg && rdy2;
    assign adv3 = v2_reg && rdy3;
    assign adv4 = v3_reg && rdy4;

    // Stage 1: divide the position by the tile size through a reciprocal multiply.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            v1_reg <= adv1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            mode1_reg  <= s_tuser;
            xprod1_reg <= ipc_pkg::CPROD_W'(s_tdata[ipc_pkg::X_LSB +: ipc_pkg::X_W])
                          * ipc_pkg::CPROD_W'(RECIP);
            yprod1_reg <= ipc_pkg::CPROD_W'(s_tdata[ipc_pkg::Y_LSB +: ipc_pkg::Y_W])
                          * ipc_pkg::CPROD_W'(RECIP);
            pix1_reg   <= s_tdata[ipc_pkg::PIX_LSB +: ipc_pkg::PIX_W];
            offs1_reg  <= s_tdata[ipc_pkg::OFFS_LSB +: ipc_pkg::OFFS_W];
        end
    end

    // Stage 2: tile index, bounds check and pixel times gain.
    assign cx1 = xprod1_reg[ipc_pkg::RECIP_SHIFT +: ipc_pkg::X_W];
    assign cy1 = yprod1_reg[ipc_pkg::RECIP_SHIFT +: ipc_pkg::Y_W];
    assign inside1 = (32'(cx1) < MAP_COLS) && (32'(cy1) < MAP_ROWS);
    assign idx1 = AW'(AW'(cy1) * AW'(MAP_COLS)) + AW'(cx1);
    assign prod1 = $signed({1'b0, pix1_reg}) * $signed(slope_gain_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            v2_reg <= adv2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            mode2_reg   <= mode1_reg;
            inside2_reg <= inside1;
            idx2_reg    <= idx1;
            prod2_reg   <= prod1;
            offs2_reg   <= offs1_reg;
        end
    end

    // Stage 3: map access and bias added; write items leave the pipeline here.
    assign map_ctrl.rd_en = adv3;
    assign map_ctrl.wr_en = adv3 && (mode2_reg == ipc_pkg::MODE_WRITE) && inside2_reg;

    ipc_offset_map #(
        .DEPTH (MAP_SLOTS),
        .AW    (AW)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (map_ctrl),
        .addr       (idx2_reg),
        .wdata      (offs2_reg),
        .rdata      (map_rdata),
        .clear_done (clear_done)
    );

    assign sum2 = ipc_pkg::SUM_W'(prod2_reg)
                + (ipc_pkg::SUM_W'($signed(bias_level_reg)) <<< ipc_pkg::LEVEL_SHL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            v3_reg <= adv3 && (mode2_reg == ipc_pkg::MODE_CORRECT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            inside3_reg <= inside2_reg;
            sum3_reg    <= sum2;
        end
    end

    // Stage 4: subtract the tile offset, take the integer part mod 256, clamp and fold.
    // A negative sum truncates to a non-positive integer, whose remainder clamps to 0.
    assign offs3 = inside3_reg ? map_rdata : '0;
    assign sum3  = sum3_reg - (ipc_pkg::SUM_W'(offs3) <<< ipc_pkg::LEVEL_SHL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (rdy4)
        begin
            v4_reg <= adv4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            pix4_reg <= sum3[ipc_pkg::SUM_W-1] ? '0 :
                        ipc_pkg::fold_level(sum3[ipc_pkg::FRAC_BITS +: ipc_pkg::PIX_W]);
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = pix4_reg;

`ifndef SYNTHESIS
    // No item enters before the offset map has been cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> clear_done)
        else $error("input transfer during map clearing pass");

    // Once cleared, the map stays cleared until the next reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_done |=> clear_done)
        else $error("map clearing pass restarted");

    // A correction item leaving stage 3 always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        adv4 |=> v4_reg)
        else $error("result lost between stage 3 and output");

    // The fold only yields even levels or full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[0] || (m_tdata == 8'hFF)))
        else $error("result outside the fold range");

    // A map write item never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv3 && (mode2_reg == ipc_pkg::MODE_WRITE)) |=> !v3_reg)
        else $error("map write item produced a result");
`endif

endmodule

/* tb/ir_photometric_pixel_correct_tb.sv */
// Self-checking testbench for the IR photometric pixel corrector: a directed table, then random
// pixel and offset-map traffic under several settings and handshake patterns.
// Depends on ipc_pkg and ir_photometric_pixel_correct, which in turn needs ipc_offset_map.
`timescale 1ns / 1ps

module ir_photometric_pixel_correct_tb;

    localparam int MAP_COLS     = ipc_pkg::FRAME_WIDTH_DEF / ipc_pkg::CELL_SIZE_DEF;
    localparam int MAP_ROWS     = ipc_pkg::FRAME_HEIGHT_DEF / ipc_pkg::CELL_SIZE_DEF;
    localparam int MAP_DEPTH    = MAP_COLS * MAP_ROWS;
    localparam int LATENCY      = 4;
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 135;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int REPORT_LIMIT = 10;

    // One row of the directed table; level is only meaningful where known is set.
    typedef struct packed {
        logic                       mode;
        logic [ipc_pkg::X_W-1:0]    x;
        logic [ipc_pkg::Y_W-1:0]    y;
        logic [ipc_pkg::PIX_W-1:0]  pv;
        logic [ipc_pkg::OFFS_W-1:0] ov;
        logic                       known;
        logic [ipc_pkg::PIX_W-1:0]  level;
    } stim_row_t;

    localparam int DIR_ROWS = 18;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    // tdata: pixel_x[9:0], pixel_y[18:10], pixel_value[26:19], offset_value[42:27], zeros
    logic [ipc_pkg::S_DATA_W-1:0]  s_tdata;
    // tuser: mode[0]
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    // tdata: corrected_pixel[7:0]
    logic [ipc_pkg::M_DATA_W-1:0]  m_tdata;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ipc_pkg::APB_AW-1:0]    paddr;
    logic [ipc_pkg::APB_DW-1:0]    pwdata;
    logic [ipc_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    // Local copy of the block's state and registers.
    logic signed [ipc_pkg::SLOPE_W-1:0] slope_reg;
    logic signed [ipc_pkg::BIAS_W-1:0]  bias_reg;
    logic signed [ipc_pkg::OFFS_W-1:0]  offset_map [MAP_DEPTH];

    logic [ipc_pkg::PIX_W-1:0] expected_levels [$];

    int  idle_pct;
    int  stall_pct;
    bit  hold_req;
    int  n_corrections;
    int  n_writes;
    int  n_checked;
    int  n_failures;
    int  n_reported;

    stim_row_t dir_table [DIR_ROWS] = '{
        '{ipc_pkg::MODE_CORRECT, 10'd0,    9'd0,   8'd0,   16'h0000, 1'b1, 8'd0},
        '{ipc_pkg::MODE_CORRECT, 10'd0,    9'd0,   8'd255, 16'h0000, 1'b1, 8'd2},
        '{ipc_pkg::MODE_CORRECT, 10'd5,    9'd7,   8'd128, 16'h0000, 1'b1, 8'd255},
        '{ipc_pkg::MODE_CORRECT, 10'd33,   9'd2,   8'd127, 16'h0000, 1'b1, 8'd254},
        '{ipc_pkg::MODE_CORRECT, 10'd70,   9'd90,  8'd129, 16'h0000, 1'b1, 8'd254},
        '{ipc_pkg::MODE_CORRECT, 10'd1023, 9'd511, 8'd64,  16'hFFFF, 1'b1, 8'd128},
        '{ipc_pkg::MODE_WRITE,   10'd16,   9'd16,  8'd255, 16'h0100, 1'b0, 8'd0},
        '{ipc_pkg::MODE_CORRECT, 10'd17,   9'd18,  8'd10,  16'h0000, 1'b0, 8'd0},
        '{ipc_pkg::MODE_CORRECT, 10'd31,   9'd31,  8'd0,   16'h0000, 1'b1, 8'd0},
        '{ipc_pkg::MODE_WRITE,   10'd639,  9'd511, 8'd0,   16'h8000, 1'b0, 8'd0},
        '{ipc_pkg::MODE_CORRECT, 10'd632,  9'd500, 8'd0,   16'h0000, 1'b0, 8'd0},
        '{ipc_pkg::MODE_WRITE,   10'd640,  9'd0,   8'd0,   16'h7FFF, 1'b0, 8'd0},
        '{ipc_pkg::MODE_CORRECT, 10'd640,  9'd0,   8'd3,   16'h0000, 1'b1, 8'd6},
        '{ipc_pkg::MODE_WRITE,   10'd0,    9'd0,   8'd0,   16'h7FFF, 1'b0, 8'd0},
        '{ipc_pkg::MODE_CORRECT, 10'd15,   9'd15,  8'd255, 16'h0000, 1'b0, 8'd0},
        '{ipc_pkg::MODE_WRITE,   10'd1023, 9'd0,   8'd0,   16'h1234, 1'b0, 8'd0},
        '{ipc_pkg::MODE_CORRECT, 10'd300,  9'd300, 8'd200, 16'h0000, 1'b1, 8'd112},
        '{ipc_pkg::MODE_CORRECT, 10'd1000, 9'd0,   8'd255, 16'h0000, 1'b1, 8'd2}
    };

    ir_photometric_pixel_correct u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Returns whether the position falls on a whole tile of the map, and that tile's index.
    function automatic bit tile_index(input logic [ipc_pkg::X_W-1:0] x,
                                      input logic [ipc_pkg::Y_W-1:0] y,
                                      output int tile);
        int cx;
        int cy;
        cx   = int'(x) / ipc_pkg::CELL_SIZE_DEF;
        cy   = int'(y) / ipc_pkg::CELL_SIZE_DEF;
        tile = cy * MAP_COLS + cx;
        return (cx < MAP_COLS) && (cy < MAP_ROWS);
    endfunction

    // Corrected level for one pixel from the current registers and map.
    function automatic logic [ipc_pkg::PIX_W-1:0] predict_corrected(
        input logic [ipc_pkg::X_W-1:0] x,
        input logic [ipc_pkg::Y_W-1:0] y,
        input logic [ipc_pkg::PIX_W-1:0] pv);
        int     tile;
        longint offs;
        longint sum;
        longint whole;
        longint rem;
        logic [ipc_pkg::PIX_W-1:0] res;
        offs = 0;
        if (tile_index(x, y, tile))
        begin
            offs = longint'(offset_map[tile]);
        end
        sum   = longint'(pv) * longint'(slope_reg) + longint'(bias_reg) * 64 - offs * 64;
        whole = sum / 16384;
        rem   = whole % 256;
        if (rem < 0)
        begin
            rem = 0;
        end
        // Triangle fold of the wrapped level.
        if (rem < 128)
        begin
            res = ipc_pkg::PIX_W'(2 * rem);
        end
        else if (rem == 128)
        begin
            res = 8'hFF;
        end
        else
        begin
            res = ipc_pkg::PIX_W'(512 - 2 * rem);
        end
        return res;
    endfunction

    task automatic report_bad(input string what, input logic [ipc_pkg::PIX_W-1:0] want,
                              input logic [ipc_pkg::PIX_W-1:0] got);
        n_failures++;
        if (n_reported < REPORT_LIMIT)
        begin
            n_reported++;
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Presents one item, optionally after random idle cycles, and updates the local state on
    // the transfer.
    task automatic send_item(input logic mode, input logic [ipc_pkg::X_W-1:0] x,
                             input logic [ipc_pkg::Y_W-1:0] y,
                             input logic [ipc_pkg::PIX_W-1:0] pv,
                             input logic [ipc_pkg::OFFS_W-1:0] ov, input logic known,
                             input logic [ipc_pkg::PIX_W-1:0] level);
        int tile;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, ov, pv, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        if (mode == ipc_pkg::MODE_WRITE)
        begin
            n_writes++;
            if (tile_index(x, y, tile))
            begin
                offset_map[tile] = ov;
            end
        end
        else
        begin
            n_corrections++;
            expected_levels = {expected_levels, (known ? level : predict_corrected(x, y, pv))};
        end
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic cfg_write(input logic reg_sel, input logic [ipc_pkg::APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_sel == ipc_pkg::REG_SLOPE)
        begin
            slope_reg = value[ipc_pkg::SLOPE_W-1:0];
        end
        else
        begin
            bias_reg = value[ipc_pkg::BIAS_W-1:0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits until every expected result has been seen, or the drain limit runs out.
    task automatic drain_results();
        int waited;
        waited = 0;
        while (expected_levels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Result checker: each transfer on the master side against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_levels.size() == 0)
            begin
                report_bad("unexpected result", 8'd0, m_tdata);
            end
            else
            begin
                if (m_tdata !== expected_levels[0])
                begin
                    report_bad("corrected_pixel mismatch", expected_levels[0], m_tdata);
                end
                void'(expected_levels.pop_front());
                n_checked++;
            end
        end
    end

    // Main sequence: reset, directed table, then random segments.
    initial
    begin
        int seg;
        int i;
        int slope_set [SEGMENTS];
        int bias_set [SEGMENTS];
        logic mode;
        logic [ipc_pkg::X_W-1:0] x;
        logic [ipc_pkg::Y_W-1:0] y;
        logic [ipc_pkg::PIX_W-1:0] pv;
        logic [ipc_pkg::OFFS_W-1:0] ov;
        bit last_write;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ipc_pkg::MODE_CORRECT;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        n_corrections = 0;
        n_writes      = 0;
        n_checked     = 0;
        n_failures    = 0;
        n_reported    = 0;
        last_write    = 1'b0;
        slope_reg     = ipc_pkg::SLOPE_RESET;
        bias_reg      = ipc_pkg::BIAS_RESET;
        for (i = 0; i < MAP_DEPTH; i++)
        begin
            offset_map[i] = '0;
        end

        // Register settings per segment: reset values, both extremes, then a mix.
        slope_set = '{16384, 131071, -131072, 0, -16384, 0, 0, 16384};
        bias_set  = '{0, 524287, -524288, 0, 12800, 0, 0, -256};
        slope_set[3] = int'($urandom_range(0, 262143)) - 131072;
        bias_set[3]  = int'($urandom_range(0, 1048575)) - 524288;
        bias_set[5]  = int'($urandom_range(0, 1048575)) - 524288;
        slope_set[6] = int'($urandom_range(0, 32767)) - 16384;
        bias_set[6]  = int'($urandom_range(0, 131071)) - 65536;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table at the reset settings; the block waits out its map clearing pass.
        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_item(dir_table[i].mode, dir_table[i].x, dir_table[i].y, dir_table[i].pv,
                      dir_table[i].ov, dir_table[i].known, dir_table[i].level);
        end

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            // Registers change only with the block idle.
            @(negedge clk);
            s_tvalid <= 1'b0;
            drain_results();
            repeat (2 * LATENCY) @(posedge clk);
            cfg_write(ipc_pkg::REG_SLOPE, ipc_pkg::APB_DW'(slope_set[seg]));
            cfg_write(ipc_pkg::REG_BIAS, ipc_pkg::APB_DW'(bias_set[seg]));

            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase

            for (i = 0; i < SEG_ITEMS; i++)
            begin
                // Long receiver hold-off while items keep coming, and one full pause.
                if (seg == 0 && i == 40)
                begin
                    hold_req = 1'b1;
                end
                if (seg == 3 && i == 60)
                begin
                    // Withdraw the last item first so that it is not taken twice.
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    drain_results();
                end

                if (last_write && $urandom_range(0, 1) == 1)
                begin
                    // Read back the cell just written, in the very next item.
                    mode = ipc_pkg::MODE_CORRECT;
                end
                else
                begin
                    mode = ($urandom_range(0, 99) < 20) ? ipc_pkg::MODE_WRITE
                                                        : ipc_pkg::MODE_CORRECT;
                    if ($urandom_range(0, 99) < 60)
                    begin
                        x = ipc_pkg::X_W'($urandom_range(0, 63));
                        y = ipc_pkg::Y_W'($urandom_range(0, 47));
                    end
                    else
                    begin
                        x = ipc_pkg::X_W'($urandom_range(0, 1023));
                        y = ipc_pkg::Y_W'($urandom_range(0, 511));
                    end
                end
                if ($urandom_range(0, 99) < 15)
                begin
                    case ($urandom_range(0, 4))
                        0: pv = 8'd0;
                        1: pv = 8'd255;
                        2: pv = 8'd128;
                        3: pv = 8'd127;
                        default: pv = 8'd129;
                    endcase
                end
                else
                begin
                    pv = ipc_pkg::PIX_W'($urandom_range(0, 255));
                end
                ov = ipc_pkg::OFFS_W'($urandom_range(0, 65535));
                send_item(mode, x, y, pv, ov, 1'b0, 8'd0);
                last_write = (mode == ipc_pkg::MODE_WRITE);
            end
        end

        // Closing: stop offering, let every result arrive, then a few more cycles.
        @(negedge clk);
        s_tvalid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        drain_results();
        repeat (4 * LATENCY) @(posedge clk);
        if (expected_levels.size() != 0)
        begin
            n_failures += expected_levels.size();
            $display("%0d expected results never arrived", expected_levels.size());
        end

        $display("Sent %0d pixel corrections and %0d offset-map writes across %0d register",
                 n_corrections, n_writes, SEGMENTS);
        $display("settings and four handshake patterns; %0d results checked, %0d failures.",
                 n_checked, n_failures);
        if (n_failures == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/ipc_pkg.sv
sv/ipc_offset_map.sv
sv/ir_photometric_pixel_correct.sv
tb/ir_photometric_pixel_correct_tb.sv
